// ----- design/rx_descriptor_frame_checker_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rx descriptor frame checker
// Shared property forms, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RX_DESCRIPTOR_FRAME_CHECKER_UNIT_ASSERT_SVH
`define RX_DESCRIPTOR_FRAME_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define RDFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rdfc assertion failed");

// next-cycle implication
`define RDFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rdfc assertion failed");

`endif

// ----- design/rdfc_pkg.sv -----
// ----------------------------------------------------------------------------
// rdfc_pkg
// Types and constants of the rx descriptor frame checker.
// ----------------------------------------------------------------------------
package rdfc_pkg;

  typedef enum logic [1:0] {
    OutReady    = 2'd0,
    OutDrop     = 2'd1,
    OutNotReady = 2'd2
  } outcome_e;

  // status word bit positions
  localparam int unsigned StOwn   = 31;
  localparam int unsigned StAfm   = 30;
  localparam int unsigned FlLsb   = 16;
  localparam int unsigned FlW     = 14;
  localparam int unsigned StEs    = 15;
  localparam int unsigned StFs    = 9;
  localparam int unsigned StLs    = 8;
  localparam int unsigned StIphce = 7;
  localparam int unsigned StFt    = 5;
  localparam int unsigned StPce   = 0;

  // low status bits equal to exactly LS | FT | PCE
  localparam logic [8:0] LowCsumOnly = 9'h121;

  localparam int unsigned CntW = 7;

  // register index decoded from paddr[2]
  localparam logic RegOffload  = 1'b0;
  localparam logic RegRingSize = 1'b1;

  typedef struct packed {
    logic                emit;
    outcome_e            outcome;
    logic [CntW-1:0]     cnt;
    logic [FlW-1:0]      len;
  } res_t;

endpackage

// ----- design/rx_descriptor_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// rx_descriptor_frame_checker_unit
// Receive descriptor frame checker, one descriptor per cycle unless the result channel stalls.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) takes one rx descriptor status item
// per cycle, in ring order. Output channel (out_valid_o / out_ready_i) gives
// one result item for a descriptor that ends a frame attempt: frame ready,
// drop, or not ready. Descriptors that only continue a frame give no item.
// Each result is registered: its descriptor is held in the input register, then
// the decision is captured in the result register.
// Throughput: one item per cycle while results are taken; the frame count update
// is a single compare-and-increment between the input and result registers.
// When the receiver stalls with a result held, the next descriptor waits in
// the input register; ones that give no result still pass and update the count.
// Reset clears both valid flags and the frame count, sets checksum_offload to 0
// and ring_size to 4. The user writes config over APB while idle; not enforced.
// ----------------------------------------------------------------------------
module rx_descriptor_frame_checker_unit
  import rdfc_pkg::*;
#(
  parameter int unsigned RING_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] desc_status_i,
  input  logic        ext_checksum_bypassed_i,
  input  logic        ext_payload_error_i,
  input  logic        ext_header_error_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  outcome_o,
  output logic [6:0]  desc_cnt_o,
  output logic [13:0] frame_length_o
);

  localparam int unsigned RingCapInt = (RING_MAX > 127) ? 127 : RING_MAX;
  localparam logic [CntW-1:0] RingCap = CntW'(RingCapInt);

  logic            offload_q;
  logic [CntW-1:0] ring_size_q;
  logic [CntW-1:0] lim;

  logic            s1_vld_q;
  logic [31:0]     s1_status_q;
  logic            s1_byp_q;
  logic            s1_pay_q;
  logic            s1_hdr_q;
  logic            s1_go;
  logic            in_acc;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  res_t            res;

  logic            out_vld_q;
  outcome_e        out_outcome_q;
  logic [CntW-1:0] out_cnt_q;
  logic [FlW-1:0]  out_len_q;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offload_q   <= 1'b0;
      ring_size_q <= CntW'(4);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegOffload:  offload_q   <= pwdata[0];
        RegRingSize: ring_size_q <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegOffload:  prdata = {31'd0, offload_q};
      RegRingSize: prdata = {{(32-CntW){1'b0}}, ring_size_q};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    if (ring_size_q == '0) begin
      lim = CntW'(1);
    end else if (ring_size_q > RingCap) begin
      lim = RingCap;
    end else begin
      lim = ring_size_q;
    end
  end

  // input register
  assign s1_go      = s1_vld_q && (!res.emit || !out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_go;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_go) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_status_q <= desc_status_i;
      s1_byp_q    <= ext_checksum_bypassed_i;
      s1_pay_q    <= ext_payload_error_i;
      s1_hdr_q    <= ext_header_error_i;
    end
  end

  rdfc_eval u_eval (
    .status_i     (s1_status_q),
    .bypassed_i   (s1_byp_q),
    .pay_err_i    (s1_pay_q),
    .hdr_err_i    (s1_hdr_q),
    .offload_i    (offload_q),
    .lim_i        (lim),
    .count_i      (count_q),
    .res_o        (res),
    .count_next_o (count_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (s1_go) begin
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_go && res.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res.emit) begin
      out_outcome_q <= res.outcome;
      out_cnt_q     <= res.cnt;
      out_len_q     <= res.len;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign outcome_o      = out_outcome_q;
  assign desc_cnt_o     = out_cnt_q;
  assign frame_length_o = out_len_q;

endmodule

// ----- design/rdfc_eval.sv -----
// ----------------------------------------------------------------------------
// rdfc_eval
// Decision logic for one descriptor against the current frame count.
// ----------------------------------------------------------------------------
module rdfc_eval
  import rdfc_pkg::*;
(
  input  logic [31:0]     status_i,
  input  logic            bypassed_i,
  input  logic            pay_err_i,
  input  logic            hdr_err_i,
  input  logic            offload_i,
  input  logic [CntW-1:0] lim_i,
  input  logic [CntW-1:0] count_i,
  output res_t            res_o,
  output logic [CntW-1:0] count_next_o
);

  logic [CntW-1:0] cnt_base;
  logic [CntW-1:0] cnt;
  logic [FlW-1:0]  len;
  logic            csum_chk;
  logic            csum_drop;

  always_comb begin
    cnt_base  = (count_i >= lim_i) ? (lim_i - CntW'(1)) : count_i;
    cnt       = cnt_base + CntW'(1);
    len       = status_i[FlLsb +: FlW];
    csum_chk  = offload_i && status_i[StFt] && (status_i[StIphce] || status_i[StPce]);
    csum_drop = csum_chk && ((status_i[8:0] != LowCsumOnly) ||
                             (!bypassed_i && (pay_err_i || hdr_err_i)));

    res_o.emit    = 1'b1;
    res_o.outcome = OutDrop;
    res_o.cnt     = cnt;
    res_o.len     = '0;

    if (status_i[StOwn]) begin
      res_o.outcome = OutNotReady;
      res_o.cnt     = '0;
    end else if (status_i[StAfm] || status_i[StEs]) begin
      res_o.outcome = OutDrop;
    end else if (csum_drop) begin
      res_o.outcome = OutDrop;
    end else if ((cnt == CntW'(1)) && !status_i[StFs]) begin
      res_o.outcome = OutDrop;
    end else if (status_i[StLs]) begin
      if (len != '0) begin
        res_o.outcome = OutReady;
        res_o.len     = len;
      end
    end else if (cnt >= lim_i) begin
      res_o.outcome = OutDrop;
    end else begin
      res_o.emit = 1'b0;
      res_o.cnt  = '0;
    end

    count_next_o = res_o.emit ? '0 : cnt;
  end

endmodule

// ----- design/rdfc_checker.sv -----
// ----------------------------------------------------------------------------
// rdfc_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "rx_descriptor_frame_checker_unit_assert.svh"

module rdfc_checker
  import rdfc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  outcome_o,
  input logic [6:0]  desc_cnt_o,
  input logic [13:0] frame_length_o
);

  logic        is_ready;
  logic        is_drop;
  logic        is_nrdy;
  logic        cnt_zero;
  logic        len_zero;
  logic [22:0] out_bus;

  assign is_ready = (outcome_o == OutReady);
  assign is_drop  = (outcome_o == OutDrop);
  assign is_nrdy  = (outcome_o == OutNotReady);
  assign cnt_zero = (desc_cnt_o == 7'd0);
  assign len_zero = (frame_length_o == 14'd0);
  assign out_bus  = {outcome_o, desc_cnt_o, frame_length_o};

  `RDFC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_bus))

  `RDFC_ASSERT_NOW(a_nrdy_empty, out_valid_o && is_nrdy, cnt_zero && len_zero)

  `RDFC_ASSERT_NOW(a_drop_fields, out_valid_o && is_drop, len_zero && !cnt_zero)

  `RDFC_ASSERT_NOW(a_ready_fields, out_valid_o && is_ready, !len_zero && !cnt_zero)

  `RDFC_ASSERT_NOW(a_outcome_code, out_valid_o, is_ready || is_drop || is_nrdy)

endmodule

bind rx_descriptor_frame_checker_unit rdfc_checker u_rdfc_checker (.*);
